// File: hdl/rbd_pkg.sv
// shared types, constants and mask tables for the rectangle blit descriptor generator
// no dependencies

package rbd_pkg;

  localparam int unsigned LineWordsDef = 80;

  localparam int unsigned XW   = 10;
  localparam int unsigned YW   = 9;
  localparam int unsigned AW   = 16;
  localparam int unsigned CW   = 4;
  localparam int unsigned InDw = 40;
  localparam int unsigned OutDw = 88;

  typedef enum logic {
    REG_FILL_COLOR = 1'b0,
    REG_PAGE_BASE  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ACT_FILL    = 1'b0,
    ACT_OUTLINE = 1'b1
  } action_e;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [XW-1:0] w;
    logic [YW-1:0] h;
    logic          last;
  } subfill_t;

  function automatic logic [7:0] first_mask(input logic [1:0] sub);
    logic [7:0] m;
    case (sub)
      2'd0:    m = 8'hF0;
      2'd1:    m = 8'h70;
      2'd2:    m = 8'h30;
      default: m = 8'h10;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] last_mask(input logic [1:0] sub);
    logic [7:0] m;
    case (sub)
      2'd0:    m = 8'h0F;
      2'd1:    m = 8'h08;
      2'd2:    m = 8'h0C;
      default: m = 8'h0E;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/rbd_expand.sv
// request expander: splits one request into its non-empty sub-fills, one per cycle while out_ready_i is high
// depends on rbd_pkg

module rbd_expand (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [9:0]          left_x_i,
  input  logic [8:0]          top_y_i,
  input  logic [9:0]          rect_width_i,
  input  logic [8:0]          rect_height_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbd_pkg::subfill_t   out_o
);
  import rbd_pkg::*;

  logic [XW-1:0] x_q, w_q;
  logic [YW-1:0] y_q, h_q;
  logic          act_q;
  logic [3:0]    pend_q, pend_d;
  logic [3:0]    new_mask, sel_oh, rem;
  logic [1:0]    sel;
  logic          fire, accept, w_nz, h_nz;

  always_comb begin
    sel = 2'd3;
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end
  end

  assign sel_oh      = 4'b0001 << sel;
  assign rem         = pend_q & ~sel_oh;
  assign out_valid_o = |pend_q;
  assign fire        = out_valid_o & out_ready_i;
  assign in_ready_o  = ~(|pend_q) | (fire & ~(|rem));
  assign accept      = in_valid_i & in_ready_o;

  assign w_nz = |rect_width_i;
  assign h_nz = |rect_height_i;

  always_comb begin
    if (action_i == ACT_OUTLINE) begin
      new_mask = {w_nz, w_nz, h_nz, h_nz};
    end else begin
      new_mask = {3'b000, w_nz & h_nz};
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = new_mask;
    end else if (fire) begin
      pend_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      x_q   <= left_x_i;
      y_q   <= top_y_i;
      w_q   <= rect_width_i;
      h_q   <= rect_height_i;
    end
  end

  always_comb begin
    out_o.x    = x_q;
    out_o.y    = y_q;
    out_o.w    = w_q;
    out_o.h    = h_q;
    out_o.last = ~(|rem);
    case (sel)
      2'd0: begin
        if (act_q == ACT_OUTLINE) begin
          out_o.w = XW'(1);
        end
      end
      2'd1: begin
        out_o.x = x_q + w_q - XW'(1);
        out_o.w = XW'(1);
      end
      2'd2: begin
        out_o.h = YW'(1);
      end
      default: begin
        out_o.y = y_q + h_q - YW'(1);
        out_o.h = YW'(1);
      end
    endcase
  end

endmodule

// File: hdl/rbd_calc.sv
// three-stage descriptor arithmetic: masks and products, address and modulo, output register
// depends on rbd_pkg

module rbd_calc #(
  parameter int unsigned LINE_WORDS = rbd_pkg::LineWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbd_pkg::subfill_t   in_i,
  input  logic [3:0]          fill_color_i,
  input  logic [15:0]         page_base_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         dest_addr_o,
  output logic [15:0]         dest_modulo_o,
  output logic [15:0]         edge_mask_o,
  output logic [15:0]         fill_pattern_o,
  output logic [8:0]          lines_minus_one_o,
  output logic [9:0]          words_minus_one_o,
  output logic                last_o
);
  import rbd_pkg::*;

  localparam logic [AW-1:0] Lw = AW'(LINE_WORDS);

  typedef struct packed {
    logic [AW-1:0] yprod;
    logic [7:0]    xword;
    logic [8:0]    ww;
    logic [7:0]    mask;
    logic [YW-1:0] hm1;
    logic          last;
  } s1_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [AW-1:0] modulo;
    logic [7:0]    mask;
    logic [YW-1:0] hm1;
    logic [XW-1:0] wm1;
    logic          last;
  } s2_t;

  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s2_t  s3_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic [24:0] prod;
  logic [11:0] wsum;
  logic [XW-1:0] xend;

  assign en3        = ~v3_q | out_ready_i;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  assign prod = {16'b0, in_i.y} * {9'b0, Lw};
  assign wsum = {2'b0, in_i.w} + {10'b0, in_i.x[1:0]} + 12'd3;
  assign xend = in_i.x + in_i.w;

  always_comb begin
    s1_d.yprod = prod[AW-1:0];
    s1_d.xword = in_i.x[XW-1:2];
    s1_d.ww    = wsum[10:2];
    s1_d.mask  = first_mask(in_i.x[1:0]) | last_mask(xend[1:0]);
    s1_d.hm1   = in_i.h - YW'(1);
    s1_d.last  = in_i.last;
  end

  always_comb begin
    s2_d.addr   = page_base_i + s1_q.yprod + {8'b0, s1_q.xword};
    s2_d.modulo = Lw - {7'b0, s1_q.ww};
    s2_d.mask   = s1_q.mask;
    s2_d.hm1    = s1_q.hm1;
    s2_d.wm1    = {1'b0, s1_q.ww} - XW'(1);
    s2_d.last   = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (en3 && v2_q) begin
      s3_q <= s2_q;
    end
  end

  assign out_valid_o       = v3_q;
  assign dest_addr_o       = s3_q.addr;
  assign dest_modulo_o     = s3_q.modulo;
  assign edge_mask_o       = {s3_q.mask, 8'h00};
  assign fill_pattern_o    = {4{fill_color_i}};
  assign lines_minus_one_o = s3_q.hm1;
  assign words_minus_one_o = s3_q.wm1;
  assign last_o            = s3_q.last;

endmodule

// File: hdl/rect_blit_descriptor_generator.sv
// top level: configuration registers, request expander and descriptor pipeline
// depends on rbd_pkg, rbd_expand, rbd_calc
//
// Turns fill and outline rectangle requests on a 4-bit-per-pixel framebuffer into
// blitter fill descriptors. A fill request gives one descriptor, an outline request up
// to four (left, right, top, bottom edge); empty sub-fills are skipped and the final
// descriptor of a request carries tlast. The request expander issues one descriptor per
// cycle while the arithmetic pipeline does not stall it; each descriptor then passes
// through the three arithmetic stages. Configuration writes are taken at once
// and must only happen while no request is in flight.

module rect_blit_descriptor_generator #(
  parameter int unsigned LINE_WORDS = rbd_pkg::LineWordsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // left_x, top_y, rect_width, rect_height, zero pad
  input  logic [rbd_pkg::InDw-1:0]     s_axis_tdata,
  // action
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // dest_addr, dest_modulo, edge_mask, fill_pattern, lines_minus_one,
  // words_minus_one, zero pad
  output logic [rbd_pkg::OutDw-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast
);
  import rbd_pkg::*;

  logic [CW-1:0] fill_color_q;
  logic [AW-1:0] page_base_q;
  subfill_t      sf;
  logic          sf_valid, sf_ready;
  logic [15:0]   dest_addr, dest_modulo, edge_mask, fill_pattern;
  logic [8:0]    lines_m1;
  logic [9:0]    words_m1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= '0;
      page_base_q  <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FILL_COLOR: fill_color_q <= cfg_data_i[CW-1:0];
        REG_PAGE_BASE:  page_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbd_expand u_expand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (s_axis_tuser),
    .left_x_i      (s_axis_tdata[9:0]),
    .top_y_i       (s_axis_tdata[18:10]),
    .rect_width_i  (s_axis_tdata[28:19]),
    .rect_height_i (s_axis_tdata[37:29]),
    .out_valid_o   (sf_valid),
    .out_ready_i   (sf_ready),
    .out_o         (sf)
  );

  rbd_calc #(
    .LINE_WORDS (LINE_WORDS)
  ) u_calc (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (sf_valid),
    .in_ready_o        (sf_ready),
    .in_i              (sf),
    .fill_color_i      (fill_color_q),
    .page_base_i       (page_base_q),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .dest_addr_o       (dest_addr),
    .dest_modulo_o     (dest_modulo),
    .edge_mask_o       (edge_mask),
    .fill_pattern_o    (fill_pattern),
    .lines_minus_one_o (lines_m1),
    .words_minus_one_o (words_m1),
    .last_o            (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, words_m1, lines_m1, fill_pattern, edge_mask, dest_modulo,
                         dest_addr};

endmodule
